// File: sv/ncpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ncpd_pkg;

   // command codes of the request channel
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   // scan coordinates span center - 63 .. center + 62, so 9 bits signed
   typedef logic signed [8:0] coord_type;
   // squared distance, at most 2 * 63 * 63
   typedef logic [12:0] sq_dist_type;
   // squared radius, at most 63 * 63
   typedef logic [11:0] rad2_type;

   typedef struct packed {
      logic        vld;     // a scan point is presented this cycle
      logic        last;    // last point of the window
      logic        cand;    // inside frame, off row/column 0, inside disk
      coord_type   row;
      coord_type   col;
      sq_dist_type sq_dist;
   } point_type;

endpackage
`default_nettype wire

// File: sv/nearest_color_pixel_in_disk_core.sv
`timescale 1ns / 1ps
`default_nettype none
// nearest matching pixel search inside a disk
//
// req channel: command 0 stores pixel_value at (pos_x, pos_y) in the frame
//   store; positions outside the frame are dropped; a write makes no response.
// req channel: command 1 searches around (pos_x, pos_y) with radius; one rsp
//   transaction follows with found, match_x, match_y (zero when nothing found).
// csr channel: writes target_color, the pixel value that counts as a match;
//   the user writes it only while no search is in flight, which the block
//   does not enforce. csr_ready is always high.
// throughput: writes are taken back to back, one per cycle, while no search
//   is busy. a search walks the 2r x 2r window one pixel per cycle through
//   the single frame store read port (radius 0 skips the walk); req_ready
//   rises in the same cycle as rsp_valid; no request is taken before then.
// stall: a finished result sits in the output register; writes and a new
//   search are accepted while it waits, and a second result waits for it.
// reset: clears control state and target_color. the frame store is not
//   cleared; a pixel must be written before a search reads it.
module nearest_color_pixel_in_disk_core
   import ncpd_pkg::*;
#(
   parameter int FRAME_WIDTH  = 128,
   parameter int FRAME_HEIGHT = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_command,
   input  wire logic [6:0]  req_pos_x,
   input  wire logic [6:0]  req_pos_y,
   input  wire logic [5:0]  req_radius,
   input  wire logic [31:0] req_pixel_value,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_found,
   output logic [6:0]       rsp_match_x,
   output logic [6:0]       rsp_match_y,
   // target color register
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_target_color
);

   localparam int Depth = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int AddrW = $clog2(Depth);

   // controller states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_FIN   = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [31:0] target_ff;

   // best match so far
   logic        hit_ff, hit_in;
   sq_dist_type best_d_ff, best_d_in;
   coord_type   best_x_ff, best_x_in;
   coord_type   best_y_ff, best_y_in;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_found_ff;
   logic [6:0] rsp_x_ff;
   logic [6:0] rsp_y_ff;

   // compare stage, aligned with the frame store read data
   point_type p1_ff;

   logic              req_fire;
   logic              search_go;
   logic              scan_start;
   logic              wr_en;
   logic [31:0]       wr_full;
   logic [AddrW-1:0]  wr_addr;
   point_type         pt;
   logic [AddrW-1:0]  rd_addr;
   logic [31:0]       rd_data;
   logic              take;
   logic              rsp_load;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign search_go = req_fire && (req_command == CMD_SEARCH);
   assign scan_start = search_go && (req_radius != 6'd0);
   assign csr_ready = 1'b1;

   // pixel write, positions outside the frame are dropped
   always_comb begin
      wr_en   = req_fire && (req_command == CMD_WRITE) &&
                (int'(req_pos_x) < FRAME_WIDTH) && (int'(req_pos_y) < FRAME_HEIGHT);
      wr_full = 32'(int'(req_pos_y) * FRAME_WIDTH + int'(req_pos_x));
      wr_addr = wr_full[AddrW-1:0];
   end

   ncpd_scan #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .start  (scan_start),
      .pos_x  (req_pos_x),
      .pos_y  (req_pos_y),
      .radius (req_radius),
      .pt     (pt),
      .addr   (rd_addr)
   );

   ncpd_ram #(
      .WIDTH (32),
      .DEPTH (Depth)
   ) u_frame (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_pixel_value),
      .rd_en   (pt.cand),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // strictly nearer wins, so ties keep the earliest point in raster order
   assign take = p1_ff.vld && p1_ff.cand && (rd_data == target_ff) &&
                 (!hit_ff || (p1_ff.sq_dist < best_d_ff));

   always_comb begin
      hit_in    = hit_ff;
      best_d_in = best_d_ff;
      best_x_in = best_x_ff;
      best_y_in = best_y_ff;
      if (search_go) begin
         hit_in    = 1'b0;
         best_d_in = '0;
         best_x_in = '0;
         best_y_in = '0;
      end else if (take) begin
         hit_in    = 1'b1;
         best_d_in = p1_ff.sq_dist;
         best_x_in = p1_ff.col;
         best_y_in = p1_ff.row;
      end
   end

   assign rsp_load = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (search_go) begin
               state_in = scan_start ? ST_SCAN : ST_FIN;
            end
         end
         ST_SCAN: begin
            if (pt.vld && pt.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         target_ff    <= '0;
         hit_ff       <= 1'b0;
         p1_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
         p1_ff        <= pt;
         if (csr_valid && csr_ready) begin
            target_ff <= csr_target_color;
         end
      end
   end

   always_ff @(posedge clock) begin
      best_d_ff  <= best_d_in;
      best_x_ff  <= best_x_in;
      best_y_ff  <= best_y_in;
      if (rsp_load) begin
         rsp_found_ff <= hit_ff;
         rsp_x_ff     <= best_x_ff[6:0];
         rsp_y_ff     <= best_y_ff[6:0];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_found   = rsp_found_ff;
   assign rsp_match_x = rsp_x_ff;
   assign rsp_match_y = rsp_y_ff;

endmodule
`default_nettype wire

// File: sv/ncpd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ncpd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: sv/ncpd_scan.sv
`timescale 1ns / 1ps
`default_nettype none
module ncpd_scan
   import ncpd_pkg::*;
#(
   parameter int FRAME_WIDTH  = 128,
   parameter int FRAME_HEIGHT = 128
) (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire logic                                         start,
   input  wire logic [6:0]                                   pos_x,
   input  wire logic [6:0]                                   pos_y,
   input  wire logic [5:0]                                   radius,
   output point_type                                         pt,
   output logic [$clog2(FRAME_WIDTH*FRAME_HEIGHT)-1:0]       addr
);

   localparam int AddrW = $clog2(FRAME_WIDTH * FRAME_HEIGHT);

   logic      run_ff, run_in;
   coord_type row_ff, row_in;
   coord_type col_ff, col_in;
   coord_type col_first_ff;
   coord_type row_last_ff;
   coord_type col_last_ff;
   coord_type px_ff;
   coord_type py_ff;
   rad2_type  r2_ff;

   coord_type        dx, dy;
   logic signed [17:0] dx_sq, dy_sq;
   sq_dist_type      sq_dist;
   logic             in_frame;
   logic             last;
   logic [31:0]      addr_full;

   // window corner and end points for a new search
   coord_type start_row, start_col, end_row, end_col;

   always_comb begin
      start_row = coord_type'({2'b00, pos_y}) - coord_type'({3'b000, radius});
      start_col = coord_type'({2'b00, pos_x}) - coord_type'({3'b000, radius});
      end_row   = coord_type'({2'b00, pos_y}) + coord_type'({3'b000, radius}) - 9'sd1;
      end_col   = coord_type'({2'b00, pos_x}) + coord_type'({3'b000, radius}) - 9'sd1;
   end

   always_comb begin
      dx      = px_ff - col_ff;
      dy      = py_ff - row_ff;
      dx_sq   = 18'(dx) * 18'(dx);
      dy_sq   = 18'(dy) * 18'(dy);
      sq_dist = {1'b0, dx_sq[11:0]} + {1'b0, dy_sq[11:0]};
      in_frame = (row_ff > 9'sd0) && (int'(row_ff) < FRAME_HEIGHT) &&
                 (col_ff > 9'sd0) && (int'(col_ff) < FRAME_WIDTH);
      last  = (row_ff == row_last_ff) && (col_ff == col_last_ff);
      addr_full = 32'(int'(row_ff) * FRAME_WIDTH + int'(col_ff));
   end

   always_comb begin
      pt.vld     = run_ff;
      pt.last    = last;
      pt.cand    = run_ff && in_frame && (sq_dist <= {1'b0, r2_ff});
      pt.row     = row_ff;
      pt.col     = col_ff;
      pt.sq_dist = sq_dist;
      addr       = addr_full[AddrW-1:0];
   end

   // raster walk over the window
   always_comb begin
      run_in = run_ff;
      row_in = row_ff;
      col_in = col_ff;
      if (start) begin
         run_in = 1'b1;
         row_in = start_row;
         col_in = start_col;
      end else if (run_ff) begin
         if (col_ff == col_last_ff) begin
            col_in = col_first_ff;
            row_in = row_ff + 9'sd1;
            if (row_ff == row_last_ff) begin
               run_in = 1'b0;
            end
         end else begin
            col_in = col_ff + 9'sd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      col_ff <= col_in;
      if (start) begin
         col_first_ff <= start_col;
         row_last_ff  <= end_row;
         col_last_ff  <= end_col;
         px_ff        <= coord_type'({2'b00, pos_x});
         py_ff        <= coord_type'({2'b00, pos_y});
         r2_ff        <= rad2_type'({6'b0, radius} * {6'b0, radius});
      end
   end

endmodule
`default_nettype wire
